// ===== hw/rtl/wpsp_pkg.sv =====
// ----------------------------------------------------------------------------
// wpsp_pkg - shared types and constants of the WAV PCM stream player
// Result codes, reject causes, the command passed from the parser to the
// result sequencer, and the fixed numbers of the RIFF/WAVE format.
// ----------------------------------------------------------------------------
package wpsp_pkg;

    // default depth of the command queue between front and back
    localparam int QUEUE_DEPTH_DEF = 8;

    // chunk tags, first file byte in the lowest bits
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] RATE_44K     = 32'd44100;
    localparam logic [31:0] RATE_48K     = 32'd48000;
    localparam logic [31:0] FMT_BODY_LEN = 32'd16;
    localparam logic [15:0] BITS_16      = 16'd16;
    localparam logic [15:0] FMT_PCM      = 16'd1;
    localparam logic [15:0] CHANS_MONO   = 16'd1;
    localparam logic [15:0] CHANS_STEREO = 16'd2;
    localparam logic [6:0]  VOL_FULL     = 7'd100;
    localparam logic [6:0]  VOL_RESET    = 7'd100;

    // divide by 100: floor(2^22 / 100), one correction step afterwards
    localparam int          RECIP_SHIFT = 22;
    localparam logic [15:0] RECIP_100   = 16'd41943;
    localparam logic [22:0] DIVISOR_100 = 23'd100;

    // result kinds
    typedef enum logic [1:0] {
        EV_SAMPLE = 2'd0,
        EV_ACCEPT = 2'd1,
        EV_REJECT = 2'd2,
        EV_END    = 2'd3
    } event_t;

    // reject causes
    typedef enum logic [3:0] {
        CAUSE_NONE      = 4'd0,
        CAUSE_NOT_WAVE  = 4'd1,
        CAUSE_SHORT_FMT = 4'd2,
        CAUSE_NOT_PCM   = 4'd3,
        CAUSE_NO_FMT    = 4'd4,
        CAUSE_BITS      = 4'd5,
        CAUSE_CHANS     = 4'd6,
        CAUSE_RATE      = 4'd7,
        CAUSE_NO_DATA   = 4'd8
    } cause_t;

    // main result of one byte, ahead of the end-of-file results
    typedef enum logic [1:0] {
        MAIN_NONE   = 2'd0,
        MAIN_SAMPLE = 2'd1,
        MAIN_ACCEPT = 2'd2,
        MAIN_REJECT = 2'd3
    } main_t;

    // one command per byte that causes results
    typedef struct packed {
        main_t              main_kind;
        logic signed [15:0] sample;    // raw, then scaled
        logic               mono;      // sample goes out left and right
        logic               chan;      // channel of a stereo sample
        cause_t             cause;
        logic               r48;
        logic               st;
        logic               rej8;      // ended before data
        logic               ends;      // end of stream
    } cmd_t;

    // one result beat
    typedef struct packed {
        event_t             ev;
        logic signed [15:0] sample;
        logic               chan;
        cause_t             cause;
        logic               r48;
        logic               st;
        logic               last;
    } result_t;

endpackage

// ===== hw/rtl/wpsp_parser.sv =====
// ----------------------------------------------------------------------------
// wpsp_parser - RIFF/WAVE header and chunk parser
// Takes one file byte per beat, walks the chunks, keeps the format fields and
// issues one command for every byte that causes results.
// ----------------------------------------------------------------------------
module wpsp_parser
    import wpsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_beat,
    input  logic [7:0] data_byte,
    input  logic       end_of_file,
    output logic       cmd_valid,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        PH_RIFF,
        PH_CHDR,
        PH_FMT,
        PH_SKIP,
        PH_PLAY,
        PH_DRAIN
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [3:0]  pos_reg, pos_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] len_reg, len_next;
    logic [15:0] fmt_tag_reg, fmt_tag_next;
    logic [15:0] chans_reg, chans_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        seen_reg, seen_next;
    logic [7:0]  low_reg, low_next;
    logic        odd_reg, odd_next;
    logic        stereo_reg, stereo_next;

    logic [31:0] tag_shift;
    logic [31:0] len_fill;
    logic [31:0] len_dec;
    logic [31:0] len_rest;
    logic        rej;
    cause_t      rej_cause;
    logic        acc;

    // next-state and command logic
    always_comb begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        tag_next     = tag_reg;
        len_next     = len_reg;
        fmt_tag_next = fmt_tag_reg;
        chans_next   = chans_reg;
        rate_next    = rate_reg;
        bits_next    = bits_reg;
        seen_next    = seen_reg;
        low_next     = low_reg;
        odd_next     = odd_reg;
        stereo_next  = stereo_reg;

        cmd.main_kind = MAIN_NONE;
        cmd.sample    = '0;
        cmd.mono      = 1'b0;
        cmd.chan      = 1'b0;
        cmd.cause     = CAUSE_NONE;
        cmd.r48       = 1'b0;
        cmd.st        = 1'b0;
        cmd.rej8      = 1'b0;
        cmd.ends      = 1'b0;

        rej       = 1'b0;
        rej_cause = CAUSE_NONE;
        acc       = 1'b0;

        tag_shift = {data_byte, tag_reg[31:8]};
        len_fill  = len_reg;
        len_fill[{pos_reg[1:0], 3'b000} +: 8] = data_byte;
        len_dec   = len_reg - 32'd1;
        len_rest  = len_reg - FMT_BODY_LEN;

        if (in_beat) begin
            unique case (phase_reg)
                // RIFF, size, WAVE
                PH_RIFF: begin
                    tag_next = tag_shift;
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == 4'd3 && tag_shift != TAG_RIFF) begin
                        rej       = 1'b1;
                        rej_cause = CAUSE_NOT_WAVE;
                    end else if (pos_reg == 4'd11) begin
                        if (tag_shift != TAG_WAVE) begin
                            rej       = 1'b1;
                            rej_cause = CAUSE_NOT_WAVE;
                        end else begin
                            phase_next = PH_CHDR;
                            pos_next   = '0;
                        end
                    end
                end
                // chunk tag and length
                PH_CHDR: begin
                    if (pos_reg < 4'd4) begin
                        tag_next = tag_shift;
                    end else begin
                        len_next = len_fill;
                    end
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == 4'd7) begin
                        pos_next = '0;
                        if (tag_reg == TAG_FMT) begin
                            if (len_fill < FMT_BODY_LEN) begin
                                rej       = 1'b1;
                                rej_cause = CAUSE_SHORT_FMT;
                            end else begin
                                phase_next = PH_FMT;
                            end
                        end else if (tag_reg == TAG_DATA) begin
                            if (!seen_reg) begin
                                rej       = 1'b1;
                                rej_cause = CAUSE_NO_FMT;
                            end else if (bits_reg != BITS_16) begin
                                rej       = 1'b1;
                                rej_cause = CAUSE_BITS;
                            end else if (chans_reg != CHANS_MONO &&
                                         chans_reg != CHANS_STEREO) begin
                                rej       = 1'b1;
                                rej_cause = CAUSE_CHANS;
                            end else if (rate_reg != RATE_44K && rate_reg != RATE_48K) begin
                                rej       = 1'b1;
                                rej_cause = CAUSE_RATE;
                            end else begin
                                acc         = 1'b1;
                                stereo_next = (chans_reg == CHANS_STEREO);
                                odd_next    = 1'b0;
                                phase_next  = PH_PLAY;
                            end
                        end else begin
                            phase_next = (len_fill == '0) ? PH_CHDR : PH_SKIP;
                        end
                    end
                end
                // first 16 bytes of the fmt body
                PH_FMT: begin
                    unique case (pos_reg)
                        4'd0:  fmt_tag_next[7:0]  = data_byte;
                        4'd1:  fmt_tag_next[15:8] = data_byte;
                        4'd2:  chans_next[7:0]    = data_byte;
                        4'd3:  chans_next[15:8]   = data_byte;
                        4'd4, 4'd5, 4'd6, 4'd7:
                               rate_next[{pos_reg[1:0], 3'b000} +: 8] = data_byte;
                        4'd14: bits_next[7:0]     = data_byte;
                        4'd15: bits_next[15:8]    = data_byte;
                        default: ;
                    endcase
                    pos_next = pos_reg + 4'd1;
                    if (pos_reg == 4'd15) begin
                        pos_next = '0;
                        if (fmt_tag_reg != FMT_PCM) begin
                            rej       = 1'b1;
                            rej_cause = CAUSE_NOT_PCM;
                        end else begin
                            seen_next  = 1'b1;
                            len_next   = len_rest;
                            phase_next = (len_rest == '0) ? PH_CHDR : PH_SKIP;
                        end
                    end
                end
                // rest of a chunk
                PH_SKIP: begin
                    len_next = len_dec;
                    if (len_dec == '0) begin
                        phase_next = PH_CHDR;
                        pos_next   = '0;
                    end
                end
                // sample bytes, low byte first
                PH_PLAY: begin
                    if (!odd_reg) begin
                        low_next = data_byte;
                        odd_next = 1'b1;
                    end else begin
                        odd_next      = 1'b0;
                        cmd.main_kind = MAIN_SAMPLE;
                        cmd.sample    = {data_byte, low_reg};
                        cmd.mono      = !stereo_reg;
                        cmd.chan      = stereo_reg & pos_reg[0];
                        if (stereo_reg) begin
                            pos_next = pos_reg + 4'd1;
                        end
                    end
                end
                PH_DRAIN: ;
                default: ;
            endcase

            if (rej) begin
                phase_next    = PH_DRAIN;
                cmd.main_kind = MAIN_REJECT;
                cmd.cause     = rej_cause;
            end
            if (acc) begin
                cmd.main_kind = MAIN_ACCEPT;
                cmd.r48       = (rate_reg == RATE_48K);
                cmd.st        = (chans_reg == CHANS_STEREO);
            end

            // end of file: close the stream and start over
            if (end_of_file) begin
                cmd.rej8     = (phase_next != PH_PLAY) && (phase_next != PH_DRAIN);
                cmd.ends     = 1'b1;
                phase_next   = PH_RIFF;
                pos_next     = '0;
                tag_next     = '0;
                len_next     = '0;
                fmt_tag_next = '0;
                chans_next   = '0;
                rate_next    = '0;
                bits_next    = '0;
                seen_next    = 1'b0;
                low_next     = '0;
                odd_next     = 1'b0;
                stereo_next  = 1'b0;
            end
        end

        cmd_valid = in_beat && ((cmd.main_kind != MAIN_NONE) || end_of_file);
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_RIFF;
            pos_reg     <= '0;
            tag_reg     <= '0;
            len_reg     <= '0;
            fmt_tag_reg <= '0;
            chans_reg   <= '0;
            rate_reg    <= '0;
            bits_reg    <= '0;
            seen_reg    <= 1'b0;
            low_reg     <= '0;
            odd_reg     <= 1'b0;
            stereo_reg  <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            tag_reg     <= tag_next;
            len_reg     <= len_next;
            fmt_tag_reg <= fmt_tag_next;
            chans_reg   <= chans_next;
            rate_reg    <= rate_next;
            bits_reg    <= bits_next;
            seen_reg    <= seen_next;
            low_reg     <= low_next;
            odd_reg     <= odd_next;
            stereo_reg  <= stereo_next;
        end
    end

endmodule

// ===== hw/rtl/wpsp_scaler.sv =====
// ----------------------------------------------------------------------------
// wpsp_scaler - three-stage volume scaler
// Multiplies the sample by the clamped volume and divides by 100 toward zero
// through a reciprocal multiply and one correction. Never stalls.
// ----------------------------------------------------------------------------
module wpsp_scaler
    import wpsp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  cmd_t       in_cmd,
    input  logic [6:0] volume,
    output logic       out_valid,
    output cmd_t       out_cmd,
    output logic [1:0] inflight
);

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    cmd_t               s1_cmd_reg, s2_cmd_reg, s3_cmd_reg;
    logic signed [22:0] s1_prod_reg, s1_prod_next;
    logic [21:0]        s2_mag_reg, s2_mag_next;
    logic               s2_neg_reg;
    logic [37:0]        s2_mr_reg, s2_mr_next;
    cmd_t               s3_cmd_next;

    logic [6:0]         vol_eff;
    logic signed [7:0]  vol_s;
    logic signed [22:0] prod_abs;
    logic [15:0]        q0;
    logic [22:0]        rem;
    logic [15:0]        q;

    // stage 1: sample times volume
    always_comb begin
        vol_eff      = (volume > VOL_FULL) ? VOL_FULL : volume;
        vol_s        = signed'({1'b0, vol_eff});
        s1_prod_next = 23'(in_cmd.sample) * 23'(vol_s);
    end

    // stage 2: magnitude times reciprocal of 100
    always_comb begin
        prod_abs    = s1_prod_reg[22] ? -s1_prod_reg : s1_prod_reg;
        s2_mag_next = prod_abs[21:0];
        s2_mr_next  = 38'(s2_mag_next) * 38'(RECIP_100);
    end

    // stage 3: correct the quotient and restore the sign
    always_comb begin
        q0  = s2_mr_reg[RECIP_SHIFT +: 16];
        rem = 23'(s2_mag_reg) - 23'(q0) * DIVISOR_100;
        q   = q0 + ((rem >= DIVISOR_100) ? 16'd1 : 16'd0);
        s3_cmd_next = s2_cmd_reg;
        s3_cmd_next.sample = s2_neg_reg ? -signed'(q) : signed'(q);
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        s1_cmd_reg  <= in_cmd;
        s1_prod_reg <= s1_prod_next;
        s2_cmd_reg  <= s1_cmd_reg;
        s2_mag_reg  <= s2_mag_next;
        s2_neg_reg  <= s1_prod_reg[22];
        s2_mr_reg   <= s2_mr_next;
        s3_cmd_reg  <= s3_cmd_next;
    end

    assign out_valid = s3_valid_reg;
    assign out_cmd   = s3_cmd_reg;
    assign inflight  = 2'({1'b0, s1_valid_reg}) + 2'({1'b0, s2_valid_reg})
                     + 2'({1'b0, s3_valid_reg});

endmodule

// ===== hw/rtl/wpsp_queue.sv =====
// ----------------------------------------------------------------------------
// wpsp_queue - command queue between the front and the back
// Small circular buffer of commands; the head is presented directly.
// ----------------------------------------------------------------------------
module wpsp_queue
    import wpsp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output cmd_t          head,
    output logic          head_valid,
    output logic [CW-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

    cmd_t          slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

endmodule

// ===== hw/rtl/wpsp_sequencer.sv =====
// ----------------------------------------------------------------------------
// wpsp_sequencer - result sequencer and output register
// Expands the head command into its result beats, one per cycle while the
// receiver is ready, and pops the command with its last beat.
// ----------------------------------------------------------------------------
module wpsp_sequencer
    import wpsp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  cmd_t    head,
    input  logic    head_valid,
    output logic    pop,
    output logic    res_valid,
    output result_t res,
    input  logic    res_ready
);

    // result slots of one command, in output order
    localparam int SLOT_MAIN = 0;
    localparam int SLOT_MONO = 1;
    localparam int SLOT_REJ8 = 2;
    localparam int SLOT_END  = 3;

    logic [3:0] done_reg, done_next;
    logic       valid_reg;
    result_t    res_reg, res_next;

    logic [3:0] present;
    logic [3:0] pending;
    logic [3:0] sel;
    logic       last;
    logic       out_free;
    logic       fire;

    always_comb begin
        present[SLOT_MAIN] = (head.main_kind != MAIN_NONE);
        present[SLOT_MONO] = (head.main_kind == MAIN_SAMPLE) && head.mono;
        present[SLOT_REJ8] = head.rej8;
        present[SLOT_END]  = head.ends;
        pending = present & ~done_reg;

        // earliest pending slot
        priority if (pending[SLOT_MAIN]) sel = 4'b0001;
        else if (pending[SLOT_MONO])     sel = 4'b0010;
        else if (pending[SLOT_REJ8])     sel = 4'b0100;
        else                             sel = 4'b1000;

        last     = ((pending & ~sel) == '0);
        out_free = !valid_reg || res_ready;
        fire     = head_valid && out_free;
        pop      = fire && last;
        done_next = done_reg;
        if (fire) begin
            done_next = last ? '0 : (done_reg | sel);
        end

        // result fields of the chosen slot
        res_next.ev     = EV_SAMPLE;
        res_next.sample = '0;
        res_next.chan   = 1'b0;
        res_next.cause  = CAUSE_NONE;
        res_next.r48    = 1'b0;
        res_next.st     = 1'b0;
        res_next.last   = last;
        unique case (1'b1)
            sel[SLOT_MAIN]: begin
                unique case (head.main_kind)
                    MAIN_SAMPLE: begin
                        res_next.sample = head.sample;
                        res_next.chan   = head.chan;
                    end
                    MAIN_ACCEPT: begin
                        res_next.ev  = EV_ACCEPT;
                        res_next.r48 = head.r48;
                        res_next.st  = head.st;
                    end
                    MAIN_REJECT: begin
                        res_next.ev    = EV_REJECT;
                        res_next.cause = head.cause;
                    end
                    default: ;
                endcase
            end
            sel[SLOT_MONO]: begin
                res_next.sample = head.sample;
                res_next.chan   = 1'b1;
            end
            sel[SLOT_REJ8]: begin
                res_next.ev    = EV_REJECT;
                res_next.cause = CAUSE_NO_DATA;
            end
            default: begin
                res_next.ev = EV_END;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
            if (out_free) begin
                valid_reg <= head_valid;
            end
        end
    end

    // output beat
    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

endmodule

// ===== hw/rtl/wav_pcm_stream_player.sv =====
// Path: a result beat passes the three scaler stages, the queue and the output
// register after the byte that causes it. Throughput: one byte per cycle while
// s_tready is high; a byte with several results holds the output longer, which
// the command queue absorbs (QUEUE_DEPTH commands, counting the scaler stages).
// Reset: aresetn low, synchronous, clears parser, scaler, queue and output;
// volume returns to 100.
// ----------------------------------------------------------------------------
// wav_pcm_stream_player - WAV file parser and PCM16 volume scaler
// Front: parser and scaler issue commands into a queue. Back: the sequencer
// turns each command into result beats.
// ----------------------------------------------------------------------------
module wav_pcm_stream_player
    import wpsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_file
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] sample_value, [16] channel,
                                   // [20:17] reject_cause, [21] rate_is_48k,
                                   // [22] source_stereo, [23] zero
    output logic [1:0]  m_tuser,   // [1:0] event_res
    output logic        m_tlast,   // run_last
    // volume register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // [6:0] volume_percent
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = CW + 1;

    logic [6:0]    vol_reg;
    logic          in_beat;
    logic          cmd_valid;
    cmd_t          cmd;
    logic          q_push;
    cmd_t          q_push_cmd;
    logic [1:0]    inflight;
    cmd_t          q_head;
    logic          q_head_valid;
    logic          q_pop;
    logic [CW-1:0] q_count;
    logic [SW-1:0] occupancy;
    result_t       res;
    logic          res_valid;

    // volume register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vol_reg <= VOL_RESET;
        end else if (cfg_valid) begin
            vol_reg <= cfg_data;
        end
    end
    assign cfg_ready = 1'b1;

    // take a byte only when its command is sure of a queue slot
    assign occupancy = SW'(q_count) + SW'(inflight);
    assign s_tready  = (occupancy < SW'(QUEUE_DEPTH));
    assign in_beat   = s_tvalid && s_tready;

    wpsp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_beat     (in_beat),
        .data_byte   (s_tdata),
        .end_of_file (s_tlast),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd)
    );

    wpsp_scaler u_scaler (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cmd_valid),
        .in_cmd    (cmd),
        .volume    (vol_reg),
        .out_valid (q_push),
        .out_cmd   (q_push_cmd),
        .inflight  (inflight)
    );

    wpsp_queue #(
        .DEPTH (QUEUE_DEPTH),
        .CW    (CW)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid),
        .count      (q_count)
    );

    wpsp_sequencer u_sequencer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .head_valid (q_head_valid),
        .pop        (q_pop),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (m_tready)
    );

    // result beat onto the port
    assign m_tvalid = res_valid;
    assign m_tdata  = {1'b0, res.st, res.r48, res.cause, res.chan, res.sample};
    assign m_tuser  = res.ev;
    assign m_tlast  = res.last;

`ifndef NO_ASSERTIONS
    // the scaler never delivers into a full queue
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_count < CW'(QUEUE_DEPTH)))
        else $error("command pushed into a full queue");

    // the sequencer only pops a held command
    a_pop_held: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (q_count != '0))
        else $error("command popped from an empty queue");

    // end of stream is always the final beat of its byte
    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == EV_END)) |-> m_tlast)
        else $error("end-of-stream beat without tlast");
`endif

endmodule

// ===== tb/wav_pcm_stream_player_test.sv =====
// ----------------------------------------------------------------------------
// wav_pcm_stream_player_test - self-checking bench for the WAV PCM player
// Builds whole RIFF/WAVE files byte by byte (well-formed files with random
// content, files broken in each way the parser rejects, raw noise), feeds
// them through bursty input traffic against a stalling receiver, and checks
// every result beat against a cycle-free model of the parser and scaler.
// ----------------------------------------------------------------------------
module wav_pcm_stream_player_test;
    import wpsp_pkg::*;

    // one byte of the file stream
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } file_byte_t;

    // parser phases of the model
    typedef enum logic [2:0] {
        WP_HEADER,
        WP_CHUNK_HDR,
        WP_FMT_BODY,
        WP_SKIP,
        WP_PLAY,
        WP_DRAIN
    } wav_parse_t;

    // kinds of generated file
    typedef enum int {
        WF_GOOD,
        WF_BAD_RIFF,
        WF_BAD_WAVE,
        WF_SHORT_FMT,
        WF_NOT_PCM,
        WF_DATA_FIRST,
        WF_BAD_BITS,
        WF_BAD_CHANS,
        WF_BAD_RATE,
        WF_NO_DATA,
        WF_CUT,
        WF_NOISE
    } wav_flavour_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = 7'd0;

    // stimulus and expectation stores
    file_byte_t  byte_q[$];
    logic [7:0]  file_buf[$];
    result_t     beats_due[$];
    int          mismatches = 0;
    int          items_total = 0;

    // model state
    logic [6:0]  vol_now = VOL_RESET;
    wav_parse_t  wp_phase;
    logic [31:0] wp_pos, wp_tag, wp_len, wp_shift, fmt_rate;
    logic [15:0] fmt_code, fmt_chans, fmt_bits;
    logic        fmt_valid, pend_odd, out_stereo;
    logic [7:0]  pend_lo;
    int          step_beats;

    // sender and receiver pacing
    int          burst_left = 0;
    int          gap_left = 0;
    file_byte_t  next_byte;
    int          rx_cycle = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    wav_pcm_stream_player dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of the parser and scaler
    // ------------------------------------------------------------------
    function automatic void clear_parser();
        wp_phase   = WP_HEADER;
        wp_pos     = '0;
        wp_tag     = '0;
        wp_len     = '0;
        wp_shift   = '0;
        fmt_code   = '0;
        fmt_chans  = '0;
        fmt_rate   = '0;
        fmt_bits   = '0;
        fmt_valid  = 1'b0;
        pend_lo    = '0;
        pend_odd   = 1'b0;
        out_stereo = 1'b0;
    endfunction

    function automatic void add_beat(event_t ev, logic [15:0] smp, logic ch, cause_t cause,
                                     logic r48, logic st);
        result_t r;
        r.ev     = ev;
        r.sample = smp;
        r.chan   = ch;
        r.cause  = cause;
        r.r48    = r48;
        r.st     = st;
        r.last   = 1'b0;
        beats_due.push_back(r);
        step_beats++;
    endfunction

    function automatic void flag_reject(cause_t cause);
        add_beat(EV_REJECT, 16'd0, 1'b0, cause, 1'b0, 1'b0);
        wp_phase = WP_DRAIN;
    endfunction

    // gain clamps at 100 %, quotient truncates toward zero
    function automatic logic [15:0] scale_sample(logic [7:0] lo_b, logic [7:0] hi_b);
        int raw_s, gain, q;
        raw_s = int'($signed({hi_b, lo_b}));
        gain  = (vol_now > VOL_FULL) ? 100 : int'(vol_now);
        q     = (raw_s * gain) / 100;
        return q[15:0];
    endfunction

    // end of an eight-byte chunk header
    function automatic void close_chunk_header();
        wp_pos = '0;
        if (wp_tag == TAG_FMT) begin
            if (wp_len < FMT_BODY_LEN) flag_reject(CAUSE_SHORT_FMT);
            else wp_phase = WP_FMT_BODY;
        end else if (wp_tag == TAG_DATA) begin
            if (!fmt_valid) flag_reject(CAUSE_NO_FMT);
            else if (fmt_bits != BITS_16) flag_reject(CAUSE_BITS);
            else if (fmt_chans != CHANS_MONO && fmt_chans != CHANS_STEREO)
                flag_reject(CAUSE_CHANS);
            else if (fmt_rate != RATE_44K && fmt_rate != RATE_48K) flag_reject(CAUSE_RATE);
            else begin
                out_stereo = (fmt_chans == CHANS_STEREO);
                pend_odd   = 1'b0;
                wp_phase   = WP_PLAY;
                add_beat(EV_ACCEPT, 16'd0, 1'b0, CAUSE_NONE, fmt_rate == RATE_48K, out_stereo);
            end
        end else begin
            wp_phase = (wp_len == 0) ? WP_CHUNK_HDR : WP_SKIP;
        end
    endfunction

    function automatic void predict_byte(logic [7:0] b, logic eof);
        logic [31:0] p;
        logic [15:0] smp;
        p = wp_pos;
        step_beats = 0;
        case (wp_phase)
            WP_HEADER: begin
                wp_tag = {b, wp_tag[31:8]};
                wp_pos = p + 1;
                if (p == 3 && wp_tag != TAG_RIFF) flag_reject(CAUSE_NOT_WAVE);
                else if (p == 11) begin
                    if (wp_tag != TAG_WAVE) flag_reject(CAUSE_NOT_WAVE);
                    else begin
                        wp_phase = WP_CHUNK_HDR;
                        wp_pos   = '0;
                    end
                end
            end
            WP_CHUNK_HDR: begin
                if (p < 4) begin
                    wp_tag = {b, wp_tag[31:8]};
                    if (p == 3) begin
                        wp_len   = '0;
                        wp_shift = '0;
                    end
                end else begin
                    wp_len   = wp_len | ({24'd0, b} << wp_shift[4:0]);
                    wp_shift = wp_shift + 8;
                end
                wp_pos = p + 1;
                if (p == 7) close_chunk_header();
            end
            WP_FMT_BODY: begin
                case (p)
                    0:  fmt_code = {8'd0, b};
                    1:  fmt_code[15:8] = b;
                    2:  fmt_chans = {8'd0, b};
                    3:  fmt_chans[15:8] = b;
                    4:  fmt_rate = {24'd0, b};
                    5:  fmt_rate[15:8] = b;
                    6:  fmt_rate[23:16] = b;
                    7:  fmt_rate[31:24] = b;
                    14: fmt_bits = {8'd0, b};
                    15: fmt_bits[15:8] = b;
                    default: ;
                endcase
                wp_pos = p + 1;
                if (p >= 15) begin
                    wp_pos = '0;
                    if (fmt_code != FMT_PCM) flag_reject(CAUSE_NOT_PCM);
                    else begin
                        fmt_valid = 1'b1;
                        wp_len    = wp_len - FMT_BODY_LEN;
                        wp_phase  = (wp_len == 0) ? WP_CHUNK_HDR : WP_SKIP;
                    end
                end
            end
            WP_SKIP: begin
                wp_len = wp_len - 1;
                if (wp_len == 0) begin
                    wp_phase = WP_CHUNK_HDR;
                    wp_pos   = '0;
                end
            end
            WP_PLAY: begin
                if (!pend_odd) begin
                    pend_lo  = b;
                    pend_odd = 1'b1;
                end else begin
                    smp      = scale_sample(pend_lo, b);
                    pend_odd = 1'b0;
                    if (out_stereo) begin
                        add_beat(EV_SAMPLE, smp, wp_pos[0], CAUSE_NONE, 1'b0, 1'b0);
                        wp_pos = wp_pos + 1;
                    end else begin
                        add_beat(EV_SAMPLE, smp, 1'b0, CAUSE_NONE, 1'b0, 1'b0);
                        add_beat(EV_SAMPLE, smp, 1'b1, CAUSE_NONE, 1'b0, 1'b0);
                    end
                end
            end
            default: ;
        endcase
        // end of file: report a missing data chunk, then close the stream
        if (eof) begin
            if (wp_phase != WP_PLAY && wp_phase != WP_DRAIN)
                add_beat(EV_REJECT, 16'd0, 1'b0, CAUSE_NO_DATA, 1'b0, 1'b0);
            add_beat(EV_END, 16'd0, 1'b0, CAUSE_NONE, 1'b0, 1'b0);
            clear_parser();
        end
        if (step_beats > 0) beats_due[beats_due.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------
    function automatic void put_le(logic [31:0] v, int nbytes);
        for (int k = 0; k < nbytes; k++) file_buf.push_back(v[8*k +: 8]);
    endfunction

    function automatic void put_random(int nbytes);
        for (int k = 0; k < nbytes; k++) file_buf.push_back(8'($urandom));
    endfunction

    // hand the buffered file to the sender, end of file on its final byte
    function automatic void commit_file();
        file_byte_t fbt;
        for (int k = 0; k < file_buf.size(); k++) begin
            fbt.data = file_buf[k];
            fbt.last = (k == file_buf.size() - 1);
            byte_q.push_back(fbt);
        end
        items_total += file_buf.size();
        file_buf.delete();
    endfunction

    // unknown chunks, zero length now and then
    function automatic void put_junk_chunks(int count);
        logic [31:0] tag_v;
        int          len;
        for (int k = 0; k < count; k++) begin
            tag_v = $urandom;
            if (tag_v == TAG_FMT || tag_v == TAG_DATA) tag_v = tag_v ^ 32'h1;
            len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            put_le(tag_v, 4);
            put_le(len, 4);
            put_random(len);
        end
    endfunction

    function automatic void put_fmt_chunk(wav_flavour_t fl);
        logic [15:0] code_v, chans_v, bits_v;
        logic [31:0] rate_v;
        int          len;
        code_v  = FMT_PCM;
        chans_v = $urandom_range(0, 1) ? CHANS_STEREO : CHANS_MONO;
        rate_v  = $urandom_range(0, 1) ? RATE_48K : RATE_44K;
        bits_v  = BITS_16;
        case (fl)
            WF_NOT_PCM: begin
                case ($urandom_range(0, 2))
                    0: code_v = 16'h0000;
                    1: code_v = 16'hFFFE;
                    default: code_v = {8'($urandom_range(1, 255)), 8'($urandom)};
                endcase
            end
            WF_BAD_CHANS: begin
                case ($urandom_range(0, 2))
                    0: chans_v = 16'd0;
                    1: chans_v = 16'd3;
                    default: chans_v = {8'($urandom_range(1, 255)), 8'($urandom)};
                endcase
            end
            WF_BAD_RATE: begin
                case ($urandom_range(0, 2))
                    0: rate_v = RATE_44K + 1;
                    1: rate_v = RATE_48K - 1;
                    default: rate_v = $urandom | 32'h8000_0000;
                endcase
            end
            WF_BAD_BITS: begin
                case ($urandom_range(0, 2))
                    0: bits_v = 16'd8;
                    1: bits_v = 16'd24;
                    default: bits_v = {8'($urandom_range(1, 255)), 8'($urandom)};
                endcase
            end
            default: ;
        endcase
        put_le(TAG_FMT, 4);
        if (fl == WF_SHORT_FMT) begin
            len = $urandom_range(0, 15);
            put_le(len, 4);
            put_random(len);
        end else begin
            len = 16 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
            put_le(len, 4);
            put_le(32'(code_v), 2);
            put_le(32'(chans_v), 2);
            put_le(rate_v, 4);
            put_random(6);
            put_le(32'(bits_v), 2);
            put_random(len - 16);
        end
    endfunction

    function automatic void build_file(wav_flavour_t fl, int data_len);
        logic [31:0] riff_v, wave_v;
        logic [15:0] smp;
        if (fl == WF_NOISE) begin
            put_random($urandom_range(1, 30));
        end else begin
            riff_v = TAG_RIFF;
            wave_v = TAG_WAVE;
            if (fl == WF_BAD_RIFF) riff_v = riff_v ^ (32'h1 << $urandom_range(0, 31));
            if (fl == WF_BAD_WAVE) wave_v = wave_v ^ (32'h1 << $urandom_range(0, 31));
            put_le(riff_v, 4);
            put_le($urandom, 4);
            put_le(wave_v, 4);
            put_junk_chunks($urandom_range(0, 2));
            if (fl != WF_DATA_FIRST) begin
                // an earlier, unusable format that the later one overrides
                if ($urandom_range(0, 5) == 0) put_fmt_chunk(WF_BAD_RATE);
                put_fmt_chunk(fl);
                put_junk_chunks($urandom_range(0, 1));
            end
            if (fl != WF_NO_DATA) begin
                put_le(TAG_DATA, 4);
                put_le($urandom, 4);
                for (int k = 0; k < data_len / 2; k++) begin
                    case ($urandom_range(0, 7))
                        0: smp = 16'h8000;
                        1: smp = 16'h7FFF;
                        2: smp = 16'hFFFF;
                        3: smp = 16'h0001;
                        default: smp = 16'($urandom);
                    endcase
                    put_le(32'(smp), 2);
                end
                // dangling odd byte
                if (data_len % 2) put_random(1);
            end
        end
        if (fl == WF_CUT) begin
            while (file_buf.size() > 1 && $urandom_range(0, 15) != 0) void'(file_buf.pop_back());
        end
        commit_file();
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of bytes with random gaps
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    next_byte = byte_q.pop_front();
                    s_tdata  <= next_byte.data;
                    s_tlast  <= next_byte.last;
                    s_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                        if ($urandom_range(0, 15) == 0) gap_left = 30;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: checks each beat, stalls on a pattern of its own
    // ------------------------------------------------------------------
    function automatic void check_beat();
        result_t got, want;
        got.ev     = event_t'(m_tuser);
        got.sample = m_tdata[15:0];
        got.chan   = m_tdata[16];
        got.cause  = cause_t'(m_tdata[20:17]);
        got.r48    = m_tdata[21];
        got.st     = m_tdata[22];
        got.last   = m_tlast;
        if (beats_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected beat: ev=%0d smp=%0d ch=%0d cause=%0d r48=%0d st=%0d last=%0d",
                         got.ev, got.sample, got.chan, got.cause, got.r48, got.st, got.last);
        end else begin
            want = beats_due.pop_front();
            if (got !== want || m_tdata[23] !== 1'b0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp ev=%0d smp=%0d ch=%0d cause=%0d r48=%0d st=%0d last=%0d",
                             want.ev, want.sample, want.chan, want.cause, want.r48, want.st,
                             want.last);
                    $display("          got ev=%0d smp=%0d ch=%0d cause=%0d r48=%0d st=%0d last=%0d pad=%b",
                             got.ev, got.sample, got.chan, got.cause, got.r48, got.st, got.last,
                             m_tdata[23]);
                end
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (m_tvalid && m_tready) begin
                check_beat();
                // first accepted format: hold off long enough to back up the input
                if (m_tuser == EV_ACCEPT && !hold_done) begin
                    hold_done = 1'b1;
                    hold_left = 400;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_cycle[7:6])
                    2'd0: m_tready <= 1'b1;
                    2'd1: m_tready <= 1'($urandom_range(0, 1));
                    2'd2: m_tready <= (rx_cycle % 3 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    // wait until every byte is taken and every beat has arrived
    task automatic wait_idle();
        while (byte_q.size() != 0 || s_tvalid || beats_due.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_volume(logic [6:0] v);
        @(posedge aclk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        vol_now = v;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [6:0]   vol_pick[5];
        logic [6:0]   v;
        bit           do_write;
        wav_flavour_t fl;
        int           len;

        vol_pick = '{7'd127, 7'd0, 7'd1, 7'd101, 7'd100};
        clear_parser();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: lone byte, bad RIFF tag ending at once, bad WAVE tag, early end
        file_buf.push_back(8'hFF);
        commit_file();
        put_le(TAG_RIFF & 32'h00FF_FFFF, 4);
        commit_file();
        put_le(TAG_RIFF, 4);
        put_le(32'h0, 4);
        put_le(TAG_WAVE ^ 32'h0F00_0000, 4);
        commit_file();
        put_le(TAG_RIFF, 2);
        commit_file();

        // random files until 100 or more bytes are queued, at most 26 files, volume
        // changed only between files while idle
        for (int i = 0; i < 26 && items_total < 100; i++) begin
            do_write = 1'b0;
            if (i < 5) begin
                v = vol_pick[i];
                do_write = 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                v = 7'($urandom_range(0, 127));
                do_write = 1'b1;
            end
            if (do_write) begin
                wait_idle();
                write_volume(v);
            end
            len = $urandom_range(0, 16);
            if (i == 0) begin
                fl  = WF_GOOD;
                len = 32;
            end else if (i <= 11) begin
                fl = wav_flavour_t'(i);
            end else if ($urandom_range(0, 9) < 6) begin
                fl = WF_GOOD;
            end else begin
                fl = wav_flavour_t'($urandom_range(1, 11));
            end
            build_file(fl, len);
        end

        wait_idle();
        repeat (16) @(posedge aclk);
        if (mismatches == 0 && beats_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
